// ===== design/sacn_pkg.sv =====
// Shared constants and types for the set-associative NRU cache lookup.
package sacn_pkg;

	// Configuration port
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_W-1:0]     cfg_val_t;

	localparam cfg_idx_t CFG_OFFSET_BITS = 2'd0;
	localparam cfg_idx_t CFG_INDEX_BITS  = 2'd1;
	localparam cfg_idx_t CFG_WAYS_IN_USE = 2'd2;

	localparam cfg_val_t RST_OFFSET_BITS = 4'd2;
	localparam cfg_val_t RST_INDEX_BITS  = 4'd4;
	localparam cfg_val_t RST_WAYS_IN_USE = 4'd8;

	// Address port width and the widest index field (index_bits up to 15)
	localparam int ADDR_W    = 32;
	localparam int IDX_W     = 15;
	// Width of the way number on the result
	localparam int WAY_OUT_W = 3;

endpackage

// ===== design/sacn_set_map.sv =====
// Maps the masked index field onto a set number, modulo SETS.
module sacn_set_map #(
	parameter int SETS  = 256,
	parameter int SET_W = 8
) (
	input  logic                      clk,
	input  logic                      load,
	input  logic [sacn_pkg::IDX_W-1:0] idx,
	output logic [SET_W-1:0]          set_idx
);

	localparam int IW = sacn_pkg::IDX_W;

	generate
		if ((SETS & (SETS - 1)) == 0) begin : g_pow2
			// Power of two: the modulo is a mask
			assign set_idx = SET_W'(idx & IW'(SETS - 1));
		end else begin : g_recip
			// Quotient by reciprocal multiply, exact for all IW-bit values
			localparam int L  = $clog2(SETS);
			localparam int SH = IW + L;
			localparam int RW = IW + 1;
			localparam longint unsigned RECIP = ((longint'(1) << SH) + SETS - 1) / SETS;

			logic [IW+RW-1:0] prod;
			logic [IW-1:0]    quot_q;
			logic [IW-1:0]    back;
			logic [IW-1:0]    rem;

			assign prod = (IW+RW)'(idx) * (IW+RW)'(RECIP);

			always_ff @(posedge clk) begin
				if (load) begin
					quot_q <= IW'(prod >> SH);
				end
			end

			// Remainder from the registered quotient
			assign back    = IW'(quot_q * IW'(SETS));
			assign rem     = idx - back;
			assign set_idx = SET_W'(rem);
		end
	endgenerate

endmodule

// ===== design/sacn_store.sv =====
// Set memories: marks and tags per set, with the clearing pass after reset.
module sacn_store #(
	parameter int SETS      = 256,
	parameter int WAYS      = 8,
	parameter int ADDR_BITS = 32,
	parameter int SET_W     = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [SET_W-1:0]          rd_set,
	input  logic                      wr_en,
	input  logic [SET_W-1:0]          wr_set,
	input  logic [WAYS*ADDR_BITS-1:0] wr_tags,
	input  logic [WAYS-1:0]           wr_valid,
	input  logic [WAYS-1:0]           wr_nru,
	output logic [WAYS*ADDR_BITS-1:0] rd_tags,
	output logic [WAYS-1:0]           rd_valid,
	output logic [WAYS-1:0]           rd_nru,
	output logic                      busy
);

	logic [2*WAYS-1:0]          meta_mem [SETS];
	logic [WAYS*ADDR_BITS-1:0]  tag_mem  [SETS];
	logic [2*WAYS-1:0]          meta_rd_q;
	logic [WAYS*ADDR_BITS-1:0]  tag_rd_q;
	logic [SET_W-1:0]           clr_q;
	logic                       busy_q;

	// Clearing pass: one set a cycle, valid off and NRU marks on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + SET_W'(1);
			if (clr_q == SET_W'(SETS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Mark memory
	always_ff @(posedge clk) begin
		if (busy_q) begin
			meta_mem[clr_q] <= {{WAYS{1'b1}}, {WAYS{1'b0}}};
		end else if (wr_en) begin
			meta_mem[wr_set] <= {wr_nru, wr_valid};
		end
		if (rd_en) begin
			meta_rd_q <= meta_mem[rd_set];
		end
	end

	// Tag memory, never cleared
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_set] <= wr_tags;
		end
		if (rd_en) begin
			tag_rd_q <= tag_mem[rd_set];
		end
	end

	assign rd_tags  = tag_rd_q;
	assign rd_valid = meta_rd_q[WAYS-1:0];
	assign rd_nru   = meta_rd_q[2*WAYS-1:WAYS];
	assign busy     = busy_q;

endmodule

// ===== design/sacn_resolve.sv =====
// Tag compare, victim choice and the updated set contents.
module sacn_resolve #(
	parameter int WAYS      = 8,
	parameter int ADDR_BITS = 32,
	parameter int WAY_W     = 3,
	parameter int WCNT_W    = 4
) (
	input  logic [ADDR_BITS-1:0]      tag,
	input  logic [WCNT_W-1:0]         ways_used,
	input  logic [WAYS*ADDR_BITS-1:0] rd_tags,
	input  logic [WAYS-1:0]           rd_valid,
	input  logic [WAYS-1:0]           rd_nru,
	output logic                      hit,
	output logic [WAY_W-1:0]          way_idx,
	output logic [WAYS*ADDR_BITS-1:0] new_tags,
	output logic [WAYS-1:0]           new_valid,
	output logic [WAYS-1:0]           new_nru
);

	always_comb begin
		logic [WAYS-1:0]  in_use;
		logic             hit_found;
		logic             vic_found;
		logic [WAY_W-1:0] hit_w;
		logic [WAY_W-1:0] vic_w;

		// Ways taking part in this lookup
		for (int w = 0; w < WAYS; w++) begin
			in_use[w] = (WCNT_W'(w) < ways_used);
		end

		// First matching way and first marked way, lowest wins
		hit_found = 1'b0;
		vic_found = 1'b0;
		hit_w     = '0;
		vic_w     = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (in_use[w] && rd_valid[w] && rd_tags[w*ADDR_BITS +: ADDR_BITS] == tag) begin
				hit_found = 1'b1;
				hit_w     = WAY_W'(w);
			end
			if (in_use[w] && rd_nru[w]) begin
				vic_found = 1'b1;
				vic_w     = WAY_W'(w);
			end
		end

		new_tags  = rd_tags;
		new_valid = rd_valid;
		new_nru   = rd_nru;
		if (hit_found) begin
			new_nru[hit_w] = 1'b0;
			way_idx        = hit_w;
		end else if (vic_found) begin
			new_nru[vic_w]                          = 1'b0;
			new_valid[vic_w]                        = 1'b1;
			new_tags[vic_w*ADDR_BITS +: ADDR_BITS]  = tag;
			way_idx                                 = vic_w;
		end else begin
			// No mark left: re-arm all ways in use, then fill way 0
			new_nru                   = rd_nru | in_use;
			new_nru[0]                = 1'b0;
			new_valid[0]              = 1'b1;
			new_tags[ADDR_BITS-1:0]   = tag;
			way_idx                   = '0;
		end
		hit = hit_found;
	end

endmodule

// ===== design/set_assoc_cache_nru_lookup.sv =====
// Set-associative cache lookup with NRU replacement: top level and sequencer.
//
// One address in, one hit/way result out. Each lookup reads its whole set
// (tags and marks) from on-chip memory into registered read outputs and
// writes the updated set back when its result enters the output register.
// With SETS a power of two a transfer goes from idle to resolve (read, then
// compare and write back); other set counts pass through the divide and read
// states for the set modulo (reciprocal multiply, then remainder) first. One
// lookup is in flight at a time, so a lookup always sees the previous write.
// After reset the mark memory is swept through every set and in_ready stays
// low until then; configuration writes are taken throughout. A finished result
// waits in the output register while the next address is taken and read.
module set_assoc_cache_nru_lookup #(
	parameter int ADDR_BITS = 32,
	parameter int SETS      = 256,
	parameter int WAYS      = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sacn_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sacn_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sacn_pkg::ADDR_W-1:0]       address,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [sacn_pkg::WAY_OUT_W-1:0]    way
);

	localparam int  IW        = sacn_pkg::IDX_W;
	localparam int  AW        = sacn_pkg::ADDR_W;
	localparam int  SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int  WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int  WCNT_W    = $clog2(WAYS + 1);
	localparam bit  POW2_SETS = ((SETS & (SETS - 1)) == 0);
	localparam logic [AW-1:0] AMASK = {AW{1'b1}} >> (AW - ADDR_BITS);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_DIV     = 2'd1;
	localparam logic [1:0] ST_READ    = 2'd2;
	localparam logic [1:0] ST_RESOLVE = 2'd3;

	logic [1:0]                  state_q;
	sacn_pkg::cfg_val_t          offset_q;
	sacn_pkg::cfg_val_t          index_q;
	sacn_pkg::cfg_val_t          ways_cfg_q;
	logic [ADDR_BITS-1:0]        tag_q;
	logic [IW-1:0]               idx_q;
	logic [SET_W-1:0]            set_q;
	logic                        out_valid_q;
	logic                        hit_q;
	logic [sacn_pkg::WAY_OUT_W-1:0] way_q;

	logic [AW-1:0]               blk;
	logic [ADDR_BITS-1:0]        tag_new;
	logic [IW-1:0]               idx_mask;
	logic [IW-1:0]               idx_new;
	logic [IW-1:0]               idx_sel;
	logic [SET_W-1:0]            set_sel;
	logic [WCNT_W-1:0]           ways_eff;
	logic                        accept;
	logic                        rd_en;
	logic                        out_free;
	logic                        res_fire;
	logic                        busy;

	logic [WAYS*ADDR_BITS-1:0]   rd_tags;
	logic [WAYS-1:0]             rd_valid;
	logic [WAYS-1:0]             rd_nru;
	logic                        res_hit;
	logic [WAY_W-1:0]            res_way;
	logic [WAYS*ADDR_BITS-1:0]   new_tags;
	logic [WAYS-1:0]             new_valid;
	logic [WAYS-1:0]             new_nru;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= sacn_pkg::RST_OFFSET_BITS;
			index_q    <= sacn_pkg::RST_INDEX_BITS;
			ways_cfg_q <= sacn_pkg::RST_WAYS_IN_USE;
		end else if (cfg_we) begin
			case (cfg_index)
				sacn_pkg::CFG_OFFSET_BITS: offset_q   <= cfg_data;
				sacn_pkg::CFG_INDEX_BITS:  index_q    <= cfg_data;
				sacn_pkg::CFG_WAYS_IN_USE: ways_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Address split: block address is the tag, low bits of it the index
	assign blk      = (address & AMASK) >> offset_q;
	assign tag_new  = ADDR_BITS'(blk);
	assign idx_mask = IW'((16'd1 << index_q) - 16'd1);
	assign idx_new  = IW'(blk) & idx_mask;

	// Effective way count: zero counts as one, clipped at WAYS
	assign ways_eff = (ways_cfg_q == '0) ? WCNT_W'(1) :
	                  (int'(ways_cfg_q) > WAYS) ? WCNT_W'(WAYS) : WCNT_W'(ways_cfg_q);

	// Handshake and sequencing strobes
	assign in_ready = (state_q == ST_IDLE) && !busy;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign res_fire = (state_q == ST_RESOLVE) && out_free;
	assign rd_en    = (accept && POW2_SETS) || (state_q == ST_READ);
	assign idx_sel  = (state_q == ST_IDLE) ? idx_new : idx_q;

	sacn_set_map #(
		.SETS  (SETS),
		.SET_W (SET_W)
	) u_set_map (
		.clk     (clk),
		.load    (state_q == ST_DIV),
		.idx     (idx_sel),
		.set_idx (set_sel)
	);

	sacn_store #(
		.SETS      (SETS),
		.WAYS      (WAYS),
		.ADDR_BITS (ADDR_BITS),
		.SET_W     (SET_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_set   (set_sel),
		.wr_en    (res_fire),
		.wr_set   (set_q),
		.wr_tags  (new_tags),
		.wr_valid (new_valid),
		.wr_nru   (new_nru),
		.rd_tags  (rd_tags),
		.rd_valid (rd_valid),
		.rd_nru   (rd_nru),
		.busy     (busy)
	);

	sacn_resolve #(
		.WAYS      (WAYS),
		.ADDR_BITS (ADDR_BITS),
		.WAY_W     (WAY_W),
		.WCNT_W    (WCNT_W)
	) u_resolve (
		.tag       (tag_q),
		.ways_used (ways_eff),
		.rd_tags   (rd_tags),
		.rd_valid  (rd_valid),
		.rd_nru    (rd_nru),
		.hit       (res_hit),
		.way_idx   (res_way),
		.new_tags  (new_tags),
		.new_valid (new_valid),
		.new_nru   (new_nru)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= POW2_SETS ? ST_RESOLVE : ST_DIV;
					end
				end
				ST_DIV:     state_q <= ST_READ;
				ST_READ:    state_q <= ST_RESOLVE;
				ST_RESOLVE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// Lookup payload
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q <= tag_new;
			idx_q <= idx_new;
		end
		if (rd_en) begin
			set_q <= set_sel;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			hit_q <= res_hit;
			way_q <= sacn_pkg::WAY_OUT_W'(res_way);
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign way       = way_q;

endmodule

// ===== design/sacn_checker.sv =====
// Port-level checks for the cache lookup, bound to the top level.
module sacn_checker #(
	parameter int WAYS = 8
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           hit,
	input logic [sacn_pkg::WAY_OUT_W-1:0] way
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(way))
		else $error("result changed while stalled");

	// One lookup at a time: no transfer right after a transfer
	a_one_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a lookup is in flight");

	// A result needs at least the memory read and the write-back
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared without a memory read");

	// Way number stays inside the ways present (WAYS)
	a_way_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(way) < WAYS))
		else $error("way beyond the ways present");

endmodule

bind set_assoc_cache_nru_lookup sacn_checker #(.WAYS(WAYS)) u_sacn_checker (.*);

// ===== tb/tb_set_assoc_cache_nru_lookup.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the set-associative NRU cache lookup block.
module tb_set_assoc_cache_nru_lookup;

	localparam int SETS         = 256;
	localparam int WAYS         = 8;
	localparam int ENTRIES      = SETS * WAYS;
	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 40;
	localparam int POOL_MAX     = 16;
	localparam int REPORT_MAX   = 10;

	// Register index with no register behind it
	localparam sacn_pkg::cfg_idx_t CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic                           hit;
		logic [sacn_pkg::WAY_OUT_W-1:0] way;
	} lookup_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	sacn_pkg::cfg_idx_t             cfg_index = '0;
	sacn_pkg::cfg_val_t             cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [sacn_pkg::ADDR_W-1:0]    address   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           hit;
	logic [sacn_pkg::WAY_OUT_W-1:0] way;

	set_assoc_cache_nru_lookup #(
		.ADDR_BITS(sacn_pkg::ADDR_W),
		.SETS     (SETS),
		.WAYS     (WAYS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.address  (address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit      (hit),
		.way      (way)
	);

	// Shadow copy of the cache state and configuration
	logic [sacn_pkg::ADDR_W-1:0] tag_mem [ENTRIES];
	bit                          valid_mem [ENTRIES];
	bit                          nru_mem [ENTRIES];
	sacn_pkg::cfg_val_t          offset_r = sacn_pkg::RST_OFFSET_BITS;
	sacn_pkg::cfg_val_t          index_r  = sacn_pkg::RST_INDEX_BITS;
	sacn_pkg::cfg_val_t          ways_r   = sacn_pkg::RST_WAYS_IN_USE;

	lookup_t                     pending_lookups[$];
	int                          fail_count = 0;
	int                          cycle_count = 0;
	int                          burst_left = 0;
	logic [sacn_pkg::ADDR_W-1:0] block_pool [POOL_MAX];
	int                          pool_size = 1;
	rx_mode_t                    rx_mode = RX_OPEN;
	int                          rx_hold = 0;

	initial begin
		for (int e = 0; e < ENTRIES; e++) begin
			tag_mem[e]   = '0;
			valid_mem[e] = 1'b0;
			nru_mem[e]   = 1'b1;
		end
	end

	// Clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Expected hit/way for one address; updates the shadow state
	function automatic lookup_t predict_lookup(logic [sacn_pkg::ADDR_W-1:0] addr);
		logic [sacn_pkg::ADDR_W-1:0] blk;
		logic [sacn_pkg::ADDR_W-1:0] idx;
		int                          n;
		int                          base;
		lookup_t                     r;
		blk  = addr >> offset_r;
		idx  = blk & ((32'd1 << index_r) - 32'd1);
		n    = (ways_r == 0) ? 1 : ((ways_r > WAYS) ? WAYS : int'(ways_r));
		base = int'(idx % SETS) * WAYS;
		// hit on a valid way
		for (int w = 0; w < n; w++) begin
			if (valid_mem[base + w] && tag_mem[base + w] == blk) begin
				nru_mem[base + w] = 1'b0;
				r.hit = 1'b1;
				r.way = sacn_pkg::WAY_OUT_W'(w);
				return r;
			end
		end
		// miss: fill the first way still marked not-recently-used
		for (int w = 0; w < n; w++) begin
			if (nru_mem[base + w]) begin
				nru_mem[base + w]   = 1'b0;
				valid_mem[base + w] = 1'b1;
				tag_mem[base + w]   = blk;
				r.hit = 1'b0;
				r.way = sacn_pkg::WAY_OUT_W'(w);
				return r;
			end
		end
		// no mark left: re-arm the ways in use, then take way 0
		for (int w = 0; w < n; w++)
			nru_mem[base + w] = 1'b1;
		nru_mem[base]   = 1'b0;
		valid_mem[base] = 1'b1;
		tag_mem[base]   = blk;
		r.hit = 1'b0;
		r.way = '0;
		return r;
	endfunction

	function automatic void note_fail(string msg);
		if (fail_count < REPORT_MAX)
			$display("%s", msg);
		fail_count++;
	endfunction

	// Send one address; bursts of random length with random gaps in between
	task automatic send_address(input logic [sacn_pkg::ADDR_W-1:0] a);
		int      gap;
		lookup_t want;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		address  = a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		want = predict_lookup(a);
		pending_lookups.insert(pending_lookups.size(), want);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic wait_drained();
		@(negedge clk);
		in_valid   = 1'b0;
		burst_left = 0;
		while (pending_lookups.size() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(input sacn_pkg::cfg_idx_t idx, input sacn_pkg::cfg_val_t val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			sacn_pkg::CFG_OFFSET_BITS: offset_r = val;
			sacn_pkg::CFG_INDEX_BITS:  index_r  = val;
			sacn_pkg::CFG_WAYS_IN_USE: ways_r   = val;
			default: ; // no register: write dropped
		endcase
	endtask

	task automatic set_config(input sacn_pkg::cfg_val_t ofs, input sacn_pkg::cfg_val_t idx,
		input sacn_pkg::cfg_val_t nways);
		write_cfg(sacn_pkg::CFG_OFFSET_BITS, ofs);
		write_cfg(sacn_pkg::CFG_INDEX_BITS, idx);
		write_cfg(sacn_pkg::CFG_WAYS_IN_USE, nways);
	endtask

	// Working set of block addresses spread over one to three sets
	task automatic build_pool();
		logic [sacn_pkg::ADDR_W-1:0] idx_mask;
		logic [sacn_pkg::ADDR_W-1:0] set_pick [3];
		logic [sacn_pkg::ADDR_W-1:0] blk;
		int                          nsets;
		idx_mask  = (32'd1 << index_r) - 32'd1;
		nsets     = $urandom_range(1, 3);
		pool_size = $urandom_range(2, POOL_MAX);
		for (int s = 0; s < 3; s++)
			set_pick[s] = $urandom;
		for (int k = 0; k < pool_size; k++) begin
			blk = $urandom >> offset_r;
			blk = (blk & ~idx_mask) | (set_pick[$urandom_range(0, nsets - 1)] & idx_mask);
			block_pool[k] = blk;
		end
	endtask

	// Mostly pool blocks with a random byte offset, some fully random noise
	function automatic logic [sacn_pkg::ADDR_W-1:0] next_address();
		logic [sacn_pkg::ADDR_W-1:0] blk;
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		blk = block_pool[$urandom_range(0, pool_size - 1)];
		return (blk << offset_r) | ($urandom & ((32'd1 << offset_r) - 32'd1));
	endfunction

	// Reset values: fills, a hit, a full set and the re-arm of its marks
	task automatic test_reset_defaults();
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'h0000_0000);
		for (int k = 1; k <= 8; k++)
			send_address(sacn_pkg::ADDR_W'(k) << 6);
		send_address(32'h0000_0040);
		send_address(32'h0000_0000);
	endtask

	// Extreme register values, set wrap and a write to the unused index
	task automatic test_config_corners();
		wait_drained();
		set_config(4'd15, 4'd15, 4'd0);
		write_cfg(CFG_UNUSED, 4'hF);
		send_address(32'h0000_0000);
		send_address(32'h0080_0000);
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'h7FFF_8000);
		wait_drained();
		set_config(4'd0, 4'd0, 4'd15);
		send_address(32'h0000_0000);
		send_address(32'h0000_0001);
		send_address(32'h0000_0002);
		send_address(32'h0000_0003);
		send_address(32'hFFFF_FFFF);
		send_address(32'h0000_0001);
		send_address(32'h8000_0000);
	endtask

	// Random traffic over several configurations, state kept across them
	task automatic test_random_traffic();
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: set_config(4'd0, 4'd0, 4'd1);
				1: set_config(4'd15, 4'd15, 4'd15);
				2: set_config(4'd4, 4'd8, 4'd8);
				3: set_config(4'd1, 4'd2, 4'd4);
				default: set_config(sacn_pkg::cfg_val_t'($urandom_range(0, 15)),
					sacn_pkg::cfg_val_t'($urandom_range(0, 15)),
					sacn_pkg::cfg_val_t'($urandom_range(0, 15)));
			endcase
			if ($urandom_range(0, 2) == 0)
				write_cfg(CFG_UNUSED, sacn_pkg::cfg_val_t'($urandom_range(0, 15)));
			build_pool();
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_address(next_address());
		end
	endtask

	// Result side: stall pattern changes mode after a random hold
	always @(negedge clk) begin
		if (rx_hold == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_hold = $urandom_range(4, 40);
		end
		rx_hold--;
		case (rx_mode)
			RX_OPEN:    out_ready = 1'b1;
			RX_RANDOM:  out_ready = 1'($urandom_range(0, 1));
			RX_SPARSE:  out_ready = (rx_hold % 4 == 0);
			RX_BLOCKED: out_ready = 1'b0;
			default:    out_ready = 1'b1;
		endcase
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_lookups.size() == 0) begin
				note_fail($sformatf("unexpected result: hit=%0b way=%0d", hit, way));
			end else begin
				want = pending_lookups.pop_front();
				if (hit !== want.hit || way !== want.way)
					note_fail($sformatf("mismatch: expected hit=%0b way=%0d, got hit=%0b way=%0d",
						want.hit, want.way, hit, way));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_config_corners();
		test_random_traffic();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_lookups.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/sacn_pkg.sv
design/sacn_set_map.sv
design/sacn_store.sv
design/sacn_resolve.sv
design/set_assoc_cache_nru_lookup.sv
design/sacn_checker.sv
tb/tb_set_assoc_cache_nru_lookup.sv
